FILE: src/abec_pkg.sv
// Shared types, constants and helpers for the ASCII expression calculator.
// No dependencies; every other file imports this package.
`default_nettype none

package abec_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned PCNT_W     = 4;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(VALUE_W);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_SPACE1,
    PH_DIGIT1,
    PH_SPACE2,
    PH_SPACE3,
    PH_DIGIT2,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_OP,
    ST_DIV_ZERO
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV,
    BK_SIGN,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    op_t                op;
    status_t            status;
  } job_t;

  function automatic logic [VALUE_W-1:0] signed_num(input logic [VALUE_W-1:0] mag,
                                                   input logic neg);
    signed_num = neg ? (~mag + VALUE_W'(1)) : mag;
  endfunction

endpackage

`default_nettype wire

FILE: src/abec_front.sv
// Front end: skips the prefix, parses operands and operator one character a cycle while accept is high.
// Pushes one job per line into the queue. Depends on abec_pkg.
`default_nettype none

module abec_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  wire [7:0]            character,
  output logic                 push,
  output abec_pkg::job_t       job
);
  import abec_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [VALUE_W-1:0] first_r, first_nxt;
  logic               neg_r, neg_nxt;
  op_t                op_r, op_nxt;
  logic               bad_r, bad_nxt;
  logic               taken;
  logic               is_digit;
  logic [VALUE_W-1:0] acc_step;

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign acc_step = (acc_r << 3) + (acc_r << 1) + VALUE_W'(character - CH_ZERO);

  assign push = accept && (character == CH_NUL);

  always_comb begin
    job.a      = first_r;
    job.b      = signed_num(acc_r, neg_r);
    job.op     = op_r;
    job.status = (bad_r || phase_r == PH_PREFIX || phase_r == PH_SPACE1 ||
                  phase_r == PH_DIGIT1 || phase_r == PH_SPACE2) ? ST_BAD_OP : ST_OK;
  end

  always_comb begin
    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    neg_nxt   = neg_r;
    op_nxt    = op_r;
    bad_nxt   = bad_r;
    taken     = 1'b0;
    if (phase_nxt == PH_PREFIX) begin
      if (pcnt_r < PCNT_W'(PREFIX_LEN)) begin
        pcnt_nxt = pcnt_r + PCNT_W'(1);
        taken    = 1'b1;
      end else begin
        phase_nxt = PH_SPACE1;
      end
    end
    if (!taken && phase_nxt == PH_SPACE1) begin
      if (character == CH_SPACE) begin
        taken = 1'b1;
      end else begin
        phase_nxt = PH_DIGIT1;
        if (character == CH_MINUS) begin
          neg_nxt = 1'b1;
          taken   = 1'b1;
        end else if (character == CH_PLUS) begin
          taken = 1'b1;
        end
      end
    end
    if (!taken && phase_nxt == PH_DIGIT1) begin
      if (is_digit) begin
        acc_nxt = acc_step;
        taken   = 1'b1;
      end else begin
        first_nxt = signed_num(acc_r, neg_nxt);
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_SPACE2;
      end
    end
    if (!taken && phase_nxt == PH_SPACE2) begin
      taken = 1'b1;
      if (character != CH_SPACE) begin
        phase_nxt = PH_SPACE3;
        unique case (character)
          CH_PLUS:  op_nxt = OP_ADD;
          CH_MINUS: op_nxt = OP_SUB;
          CH_STAR:  op_nxt = OP_MUL;
          CH_SLASH: op_nxt = OP_DIV;
          default: begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
    if (!taken && phase_nxt == PH_SPACE3) begin
      if (character == CH_SPACE) begin
        taken = 1'b1;
      end else begin
        phase_nxt = PH_DIGIT2;
        if (character == CH_MINUS) begin
          neg_nxt = 1'b1;
          taken   = 1'b1;
        end else if (character == CH_PLUS) begin
          taken = 1'b1;
        end
      end
    end
    if (!taken && phase_nxt == PH_DIGIT2) begin
      if (is_digit) begin
        acc_nxt = acc_step;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r <= PH_PREFIX;
      pcnt_r  <= '0;
      acc_r   <= '0;
      first_r <= '0;
      neg_r   <= 1'b0;
      op_r    <= OP_ADD;
      bad_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pcnt_r  <= pcnt_nxt;
      acc_r   <= acc_nxt;
      first_r <= first_nxt;
      neg_r   <= neg_nxt;
      op_r    <= op_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/abec_queue.sv
// Short job queue between front end and back end.
// Depends on abec_pkg for the job type and depth.
`default_nettype none

module abec_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  abec_pkg::job_t       push_job,
  input  wire                  pop,
  output abec_pkg::job_t       head_job,
  output logic                 not_empty,
  output logic                 full
);
  import abec_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    wrap_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_job  = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/abec_back.sv
// Back end: add, subtract, multiply, and a one-bit-a-cycle restoring divider.
// Holds the result in the output register. Depends on abec_pkg.
`default_nettype none

module abec_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  abec_pkg::job_t               head_job,
  input  wire                          not_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [abec_pkg::VALUE_W-1:0] res_value,
  output abec_pkg::status_t            res_status
);
  import abec_pkg::*;

  back_state_t          state_r, state_nxt;
  job_t                 job_r;
  logic [VALUE_W-1:0]   rem_r, quo_r, mb_r;
  logic                 qneg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0]   value_r;
  status_t              status_r;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W:0]     trial;
  logic [VALUE_W-1:0]   ma, mb;
  logic                 div_last;

  assign prod     = job_r.a * job_r.b;
  assign ma       = job_r.a[VALUE_W-1] ? (~job_r.a + VALUE_W'(1)) : job_r.a;
  assign mb       = job_r.b[VALUE_W-1] ? (~job_r.b + VALUE_W'(1)) : job_r.b;
  assign trial    = {rem_r, quo_r[VALUE_W-1]} - {1'b0, mb_r};
  assign div_last = (cnt_r == DIV_CNT_W'(VALUE_W - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (not_empty) state_nxt = BK_EXEC;
      BK_EXEC: begin
        if (job_r.status == ST_OK && job_r.op == OP_DIV && job_r.b != '0) begin
          state_nxt = BK_DIV;
        end else begin
          state_nxt = BK_OUT;
        end
      end
      BK_DIV:  if (div_last) state_nxt = BK_SIGN;
      BK_SIGN: state_nxt = BK_OUT;
      BK_OUT:  if (!out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = not_empty;
      BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        job_r <= head_job;
      end
      BK_EXEC: begin
        value_r  <= '0;
        status_r <= job_r.status;
        rem_r    <= '0;
        quo_r    <= ma;
        mb_r     <= mb;
        qneg_r   <= job_r.a[VALUE_W-1] ^ job_r.b[VALUE_W-1];
        cnt_r    <= '0;
        if (job_r.status == ST_OK) begin
          case (job_r.op)
            OP_ADD: value_r <= job_r.a + job_r.b;
            OP_SUB: value_r <= job_r.a - job_r.b;
            OP_MUL: value_r <= prod[VALUE_W-1:0];
            default: begin
              if (job_r.b == '0) begin
                status_r <= ST_DIV_ZERO;
              end
            end
          endcase
        end
      end
      BK_DIV: begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        quo_r <= {quo_r[VALUE_W-2:0], ~trial[VALUE_W]};
        rem_r <= trial[VALUE_W] ? {rem_r[VALUE_W-2:0], quo_r[VALUE_W-1]}
                                : trial[VALUE_W-1:0];
      end
      BK_SIGN: begin
        value_r <= qneg_r ? (~quo_r + VALUE_W'(1)) : quo_r;
      end
      default: ;
    endcase
  end

  assign res_value  = value_r;
  assign res_status = status_r;

endmodule

`default_nettype wire

FILE: src/ascii_binary_expression_calculator.sv
// Top level of the ASCII expression calculator: front end, job queue, back end.
// Depends on abec_pkg, abec_front, abec_queue and abec_back.
//
//   channel | direction | ports                          | item
//   in      | input     | in_valid, in_stall, in_character | one command byte, 0 ends line
//   out     | output    | out_valid, out_stall, out_value, out_status | one result per line
//
// One character is taken per cycle while the queue has room; in_stall rises only
// when two finished lines wait in the queue.
// Per line the back end loads the job, computes add, subtract and multiply; a divide by
// non-zero also runs the one-bit-a-cycle divider and a sign fix; results hold until taken.
// Reset is synchronous and clears parser, queue and back-end control state.
`default_nettype none

module ascii_binary_expression_calculator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [7:0]                          in_character,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [abec_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                          out_status
);
  import abec_pkg::*;

  logic               accept;
  logic               push;
  job_t               push_job;
  job_t               head_job;
  logic               pop;
  logic               not_empty;
  logic               full;
  logic [VALUE_W-1:0] res_value;
  status_t            res_status;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  abec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .character (in_character),
    .push      (push),
    .job       (push_job)
  );

  abec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (not_empty),
    .full      (full)
  );

  abec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_value  (res_value),
    .res_status (res_status)
  );

  assign out_value  = $signed(res_value);
  assign out_status = res_status;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job popped from an empty queue");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("error result carries a non-zero value");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !out_valid)
    else $error("job taken while a result was still presented");

endmodule

`default_nettype wire
